/* rtl/assert_macros.svh */
// Assertion helpers shared by the line rasterizer RTL.
// Each macro expects clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lsgp_pkg.sv */
// Package for the line segment grid point rasterizer.
// Widths, the segment descriptor type and the stepper state type; no dependencies.
`timescale 1ns / 1ps

package lsgp_pkg;

  localparam int COORD_BITS = 6;
  localparam int DM_W       = COORD_BITS + 1;  // signed minor delta
  localparam int REM_W      = COORD_BITS + 3;  // signed rounding remainder

  localparam int IN_BITS    = 4 * COORD_BITS + 2;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * COORD_BITS;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  // queue depth, power of two
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                   x_major;
    logic                   maj_dec;    // major coordinate counts down
    coord_t                 maj0;
    coord_t                 min0;
    logic signed [DM_W-1:0] dm;         // minor delta over the run
    coord_t                 n;          // major length, nonzero
    coord_t                 fin;        // index of final step
    logic                   with_start;
  } seg_desc_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } step_st_t;

endpackage

/* rtl/lsgp_front.sv */
// Front end of the rasterizer: unpacks a segment, finds the major axis
// and run bounds, drops empty runs and pushes a descriptor. Uses lsgp_pkg.
`timescale 1ns / 1ps

module lsgp_front (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [lsgp_pkg::IN_W-1:0] in_tdata,
  input  logic                      q_full,
  output logic                      q_push,
  output lsgp_pkg::seg_desc_t       q_data
);

  localparam int CB = lsgp_pkg::COORD_BITS;

  lsgp_pkg::coord_t sx, sy, ex, ey;
  logic             ws, we;
  logic signed [CB:0] dx, dy, ndx, ndy;
  lsgp_pkg::coord_t adx, ady, n, fin;
  logic             x_major, empty_run;

  always_comb begin
    sx  = in_tdata[CB-1:0];
    sy  = in_tdata[2*CB-1:CB];
    ex  = in_tdata[3*CB-1:2*CB];
    ey  = in_tdata[4*CB-1:3*CB];
    ws  = in_tdata[4*CB];
    we  = in_tdata[4*CB+1];

    dx  = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy  = $signed({1'b0, ey}) - $signed({1'b0, sy});
    ndx = -dx;
    ndy = -dy;
    adx = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
    ady = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];

    x_major = (adx >= ady);
    n       = x_major ? adx : ady;
    fin     = we ? n : n - CB'(1);
    // nothing to emit: zero length, or a single step with both ends dropped
    empty_run = (n == '0) || ((fin == '0) && !ws);

    q_data.x_major    = x_major;
    q_data.maj_dec    = x_major ? dx[CB] : dy[CB];
    q_data.maj0       = x_major ? sx : sy;
    q_data.min0       = x_major ? sy : sx;
    q_data.dm         = x_major ? dy : dx;
    q_data.n          = n;
    q_data.fin        = fin;
    q_data.with_start = ws;

    in_tready = !q_full;
    q_push    = in_tvalid && !q_full && !empty_run;
  end

endmodule

/* rtl/lsgp_fifo.sv */
// Small descriptor queue between the front end and the stepper.
// Holds lsgp_pkg::seg_desc_t entries; depth from lsgp_pkg::Q_DEPTH.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsgp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lsgp_pkg::seg_desc_t push_data,
  output logic                full,
  input  logic                pop,
  output lsgp_pkg::seg_desc_t pop_data,
  output logic                empty
);

  localparam int PW = lsgp_pkg::Q_PTR_W;
  localparam int CW = lsgp_pkg::Q_CNT_W;

  lsgp_pkg::seg_desc_t mem_r [lsgp_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full     = (cnt_r == CW'(lsgp_pkg::Q_DEPTH));
    empty    = (cnt_r == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_data = mem_r[rd_ptr_r];

    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMPL(a_no_push_full, push, !full, "descriptor pushed into a full queue")
  `ASSERT_IMPL(a_no_pop_empty, pop, !empty, "descriptor popped from an empty queue")

endmodule

/* rtl/lsgp_back.sv */
// Stepper: walks one segment along its major axis, tracking the rounded
// minor coordinate with a quotient/remainder pair. Uses lsgp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsgp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  lsgp_pkg::seg_desc_t        q_data,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lsgp_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);

  localparam int CB = lsgp_pkg::COORD_BITS;
  localparam int RW = lsgp_pkg::REM_W;

  lsgp_pkg::step_st_t  state_r, state_nxt;
  lsgp_pkg::seg_desc_t desc_r, desc_nxt;
  lsgp_pkg::coord_t    maj_r, maj_nxt, q_r, q_nxt, idx_r, idx_nxt;
  logic signed [RW-1:0] rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  lsgp_pkg::coord_t    px_r, px_nxt, py_r, py_nxt;
  logic                last_r, last_nxt;

  logic signed [RW-1:0] two_n, dm2, rem_sum;
  logic emit, out_free, step_ok, at_end;

  always_comb begin
    two_n    = $signed({2'b00, desc_r.n, 1'b0});
    dm2      = $signed({desc_r.dm[CB], desc_r.dm, 1'b0});
    rem_sum  = rem_r + dm2;
    emit     = (idx_r != '0) || desc_r.with_start;
    out_free = !out_valid_r || out_tready;
    step_ok  = (state_r == lsgp_pkg::ST_RUN) && (!emit || out_free);
    at_end   = (idx_r == desc_r.fin);

    state_nxt     = state_r;
    desc_nxt      = desc_r;
    maj_nxt       = maj_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    case (state_r)
      lsgp_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          desc_nxt  = q_data;
          maj_nxt   = q_data.maj0;
          q_nxt     = q_data.min0;
          rem_nxt   = $signed({3'b000, q_data.n});  // start at m0 + 1/2
          idx_nxt   = '0;
          state_nxt = lsgp_pkg::ST_RUN;
        end
      end
      lsgp_pkg::ST_RUN: begin
        if (step_ok) begin
          if (emit) begin
            out_valid_nxt = 1'b1;
            px_nxt   = desc_r.x_major ? maj_r : q_r;
            py_nxt   = desc_r.x_major ? q_r : maj_r;
            last_nxt = at_end;
          end
          if (at_end) begin
            state_nxt = lsgp_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + CB'(1);
            maj_nxt = desc_r.maj_dec ? maj_r - CB'(1) : maj_r + CB'(1);
            // |2*dm| <= 2n, so one correction keeps the remainder in [0, 2n)
            if (rem_sum >= two_n) begin
              rem_nxt = rem_sum - two_n;
              q_nxt   = q_r + CB'(1);
            end else if (rem_sum < 0) begin
              rem_nxt = rem_sum + two_n;
              q_nxt   = q_r - CB'(1);
            end else begin
              rem_nxt = rem_sum;
            end
          end
        end
      end
      default: state_nxt = lsgp_pkg::ST_IDLE;
    endcase

    out_tvalid = out_valid_r;
    out_tdata  = lsgp_pkg::OUT_W'({py_r, px_r});
    out_tlast  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsgp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    maj_r  <= maj_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    idx_r  <= idx_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
  end

  `ASSERT_IMPL(a_idx_bound, state_r == lsgp_pkg::ST_RUN, idx_r <= desc_r.fin,
               "step index ran past the final step")
  `ASSERT_IMPL(a_rem_range, state_r == lsgp_pkg::ST_RUN, (rem_r >= 0) && (rem_r < two_n),
               "rounding remainder out of range")
  `ASSERT_NEXT(a_end_idle, step_ok && at_end, state_r == lsgp_pkg::ST_IDLE,
               "stepper did not return to idle after the final step")

endmodule

/* rtl/line_segment_grid_points_core.sv */
// Line segment grid point rasterizer, top level.
// Instantiates lsgp_front, lsgp_fifo and lsgp_back; uses lsgp_pkg.
//
// Usage:
//   The in_ channel takes one segment per item: two endpoints on a
//   64 x 64 grid plus with_start / with_end flags. The out_ channel returns
//   the grid points of that segment in stepping order, one item per point,
//   with out_tlast set on the final point. The minor coordinate is the
//   exact interpolation rounded half away from zero, tracked by an
//   incremental quotient/remainder stepper (no divider).
//   Segments that give no points (zero length, or a single step with both
//   ends excluded) are absorbed by the front end and produce nothing.
// Flow:
//   A segment's first point passes the descriptor queue, the stepper load
//   and, when the start point is excluded, a step without output before
//   it reaches the output register. The stepper then emits one point per
//   cycle unless out_tready stalls it; a segment with n major steps takes
//   a load step and at most n + 1 steps. A two-entry descriptor queue lets
//   the front end take further segments while the stepper works.
// Reset and stall:
//   rst_n (synchronous, active low) empties the queue, idles the stepper
//   and drops out_tvalid. A low out_tready with a point pending holds the
//   stepper at its next emitting step, the pending point held in the output
//   register; in_tready falls only once the descriptor queue is full.
`timescale 1ns / 1ps

module line_segment_grid_points_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [5:0] start_x, [11:6] start_y, [17:12] end_x, [23:18] end_y,
  // [24] with_start, [25] with_end, rest zero
  input  logic [lsgp_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [5:0] point_x, [11:6] point_y, rest zero
  output logic [lsgp_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);

  lsgp_pkg::seg_desc_t push_desc, pop_desc;
  logic                q_push, q_full, q_pop, q_empty;

  // classify and drop empty runs
  lsgp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_desc)
  );

  // decouples acceptance from stepping
  lsgp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_desc),
    .empty     (q_empty)
  );

  // one point per cycle unless out_tready stalls, output register toward out_
  lsgp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
